// ----- rtl/jsu_pkg.sv -----
// jsu_pkg: shared types, codes and character helpers of the json string unescaper
// used by jsu_step, jsu_obuf and json_string_unescaper_unit; depends on nothing
`default_nettype none

package jsu_pkg;

	localparam int MAX_RES = 4;
	localparam int CNT_W   = $clog2(MAX_RES + 1);
	localparam int IDX_W   = $clog2(MAX_RES);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_STR  = 3'd1,
		PH_ESC  = 3'd2,
		PH_HEX  = 3'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
	localparam logic [2:0] ERR_BAD_ESC   = 3'd2;
	localparam logic [2:0] ERR_BAD_HEX   = 3'd3;
	localparam logic [2:0] ERR_CTRL      = 3'd4;
	localparam logic [2:0] ERR_UNTERM    = 3'd5;

	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_BSLASH     = 8'h5C;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;

	localparam logic [15:0] CP_1B_LIMIT  = 16'h0080;
	localparam logic [15:0] CP_2B_LIMIT  = 16'h0800;
	localparam logic [7:0]  UTF8_CONT    = 8'h80;
	localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
		logic [2:0] error_code;
	} res_t;

	// results produced by one input transaction
	typedef struct packed {
		res_t [MAX_RES-1:0] res;
		logic [CNT_W-1:0]   cnt;
	} step_res_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} nibble_t;

	typedef struct packed {
		logic       valid;
		logic       is_u;
		logic [7:0] value;
	} esc_t;

	function automatic nibble_t hex_nibble(input logic [7:0] c);
		nibble_t r;
		r.valid = 1'b1;
		r.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r.value = c[3:0];
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			r.value = c[3:0] + 4'd9;
		else
			r.valid = 1'b0;
		return r;
	endfunction

	function automatic esc_t esc_decode(input logic [7:0] c);
		esc_t r;
		r.valid = 1'b1;
		r.is_u  = 1'b0;
		r.value = 8'h00;
		case (c)
			CH_QUOTE:  r.value = CH_QUOTE;
			CH_BSLASH: r.value = CH_BSLASH;
			CH_SLASH:  r.value = CH_SLASH;
			8'h62:     r.value = 8'h08;
			8'h66:     r.value = 8'h0C;
			8'h6E:     r.value = 8'h0A;
			8'h72:     r.value = 8'h0D;
			8'h74:     r.value = 8'h09;
			8'h75:     r.is_u  = 1'b1;
			default:   r.valid = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/jsu_step.sv -----
// jsu_step: parser state registers and the single-pass decode of one character
// into up to four results; depends on jsu_pkg
`default_nettype none

module jsu_step (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               accept,
	input  wire  [7:0]        in_byte,
	input  wire               end_of_input,
	output jsu_pkg::step_res_t step
);
	import jsu_pkg::*;

	phase_t      phase_q, phase_nx;
	logic [1:0]  hex_count_q, hex_count_nx;
	logic [15:0] code_point_q, code_point_nx;

	nibble_t     nib;
	esc_t        esc;
	logic [15:0] cp_full;
	logic        term;
	res_t        err_res;

	assign nib     = hex_nibble(in_byte);
	assign esc     = esc_decode(in_byte);
	assign cp_full = {code_point_q[11:0], nib.value};

	always_comb begin
		err_res            = '0;
		err_res.kind       = KIND_ERR;
		step               = '0;
		phase_nx           = phase_q;
		hex_count_nx       = hex_count_q;
		code_point_nx      = code_point_q;
		term               = 1'b0;
		case (phase_q)
			PH_STR: begin
				if (in_byte == CH_QUOTE) begin
					step.res[0].kind = KIND_DONE;
					step.cnt         = CNT_W'(1);
					phase_nx         = PH_IDLE;
					term             = 1'b1;
				end else if (in_byte == CH_BSLASH) begin
					phase_nx = PH_ESC;
				end else if (in_byte < CH_CTRL_LIMIT) begin
					step.res[0]            = err_res;
					step.res[0].error_code = ERR_CTRL;
					step.cnt               = CNT_W'(1);
					phase_nx               = PH_IDLE;
					hex_count_nx           = 2'd0;
					code_point_nx          = 16'd0;
					term                   = 1'b1;
				end else begin
					step.res[0].out_byte = in_byte;
					step.cnt             = CNT_W'(1);
				end
			end
			PH_ESC: begin
				if (!esc.valid) begin
					step.res[0]            = err_res;
					step.res[0].error_code = ERR_BAD_ESC;
					step.cnt               = CNT_W'(1);
					phase_nx               = PH_IDLE;
					hex_count_nx           = 2'd0;
					code_point_nx          = 16'd0;
					term                   = 1'b1;
				end else if (esc.is_u) begin
					phase_nx      = PH_HEX;
					hex_count_nx  = 2'd0;
					code_point_nx = 16'd0;
				end else begin
					step.res[0].out_byte = esc.value;
					step.cnt             = CNT_W'(1);
					phase_nx             = PH_STR;
				end
			end
			PH_HEX: begin
				if (!nib.valid) begin
					step.res[0]            = err_res;
					step.res[0].error_code = ERR_BAD_HEX;
					step.cnt               = CNT_W'(1);
					phase_nx               = PH_IDLE;
					hex_count_nx           = 2'd0;
					code_point_nx          = 16'd0;
					term                   = 1'b1;
				end else if (hex_count_q != 2'd3) begin
					hex_count_nx  = hex_count_q + 2'd1;
					code_point_nx = cp_full;
				end else begin
					// fourth digit: utf-8 encode the gathered code point
					if (cp_full < CP_1B_LIMIT) begin
						step.res[0].out_byte = cp_full[7:0];
						step.cnt             = CNT_W'(1);
					end else if (cp_full < CP_2B_LIMIT) begin
						step.res[0].out_byte = UTF8_LEAD2 | {3'b000, cp_full[10:6]};
						step.res[1].out_byte = UTF8_CONT | {2'b00, cp_full[5:0]};
						step.cnt             = CNT_W'(2);
					end else begin
						step.res[0].out_byte = UTF8_LEAD3 | {4'b0000, cp_full[15:12]};
						step.res[1].out_byte = UTF8_CONT | {2'b00, cp_full[11:6]};
						step.res[2].out_byte = UTF8_CONT | {2'b00, cp_full[5:0]};
						step.cnt             = CNT_W'(3);
					end
					phase_nx      = PH_STR;
					hex_count_nx  = 2'd0;
					code_point_nx = 16'd0;
				end
			end
			default: begin
				if (in_byte != CH_QUOTE) begin
					step.res[0]            = err_res;
					step.res[0].error_code = ERR_NO_QUOTE;
					step.cnt               = CNT_W'(1);
					phase_nx               = PH_IDLE;
					hex_count_nx           = 2'd0;
					code_point_nx          = 16'd0;
					term                   = 1'b1;
				end else begin
					phase_nx      = PH_STR;
					hex_count_nx  = 2'd0;
					code_point_nx = 16'd0;
				end
			end
		endcase
		// buffer ran out before the string closed
		if (end_of_input && !term) begin
			step.res[step.cnt[IDX_W-1:0]]            = err_res;
			step.res[step.cnt[IDX_W-1:0]].error_code = ERR_UNTERM;
			step.cnt                                 = step.cnt + CNT_W'(1);
			phase_nx                                 = PH_IDLE;
			hex_count_nx                             = 2'd0;
			code_point_nx                            = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			hex_count_q  <= 2'd0;
			code_point_q <= 16'd0;
		end else if (accept) begin
			phase_q      <= phase_nx;
			hex_count_q  <= hex_count_nx;
			code_point_q <= code_point_nx;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/jsu_obuf.sv -----
// jsu_obuf: result register holding up to four results of one transaction,
// sent out one per beat; depends on jsu_pkg
`default_nettype none

module jsu_obuf (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                load,
	input  jsu_pkg::step_res_t step,
	output logic               free,
	output logic               m_valid,
	input  wire                m_ready,
	output jsu_pkg::res_t      m_res,
	output logic               m_last
);
	import jsu_pkg::*;

	res_t [MAX_RES-1:0] res_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic               take;
	logic               drained;

	assign m_valid = (cnt_q != '0);
	assign m_res   = res_q[idx_q];
	assign m_last  = ({1'b0, idx_q} == cnt_q - CNT_W'(1));
	assign take    = m_valid && m_ready;
	assign drained = take && m_last;
	// a new transaction may enter while the final result leaves
	assign free    = !m_valid || drained;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load && step.cnt != '0) begin
			cnt_q <= step.cnt;
			idx_q <= '0;
		end else if (drained) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= step.res;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RES))
		else $error("result count above buffer depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid |-> ({1'b0, idx_q} < cnt_q))
		else $error("read index past result count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(take && !m_last) |=> m_valid)
		else $error("burst of results broken before its last beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid && (m_res.kind == KIND_DONE || m_res.kind == KIND_ERR)) |-> m_last)
		else $error("done or error result not final for its transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid && m_res.kind != KIND_ERR) |-> (m_res.error_code == ERR_NONE))
		else $error("error code set on a non-error result");

endmodule

`default_nettype wire

// ----- rtl/json_string_unescaper_unit.sv -----
// json_string_unescaper_unit: top level of the json string unescaper
// depends on jsu_pkg, jsu_step and jsu_obuf
//
// Input stream: one raw character per transaction, starting at the opening
// quote; s_axis_tlast marks the last character of the buffer. Output stream:
// one result per transaction, a data byte, a done marker or an error with its
// code; m_axis_tlast marks the final result caused by an input character.
// A character's first result appears in the cycle after it is taken.
// Throughput: one character per cycle while each yields at most one result
// and the receiver takes it; a character with more results holds the input
// until its last result is being taken, since the four-entry result register
// sends one result per beat (a closing \u escape gives up to three bytes,
// plus an error if the buffer ends there). Characters that yield no result
// (backslash, opening quote, early hex digits) show nothing on the output.
// When the receiver stalls, results wait in the result register and the
// input stays ready only while the last waiting result is being taken.
// Reset returns the parser to idle, waiting for an opening quote, and
// empties the result register.
`default_nettype none

module json_string_unescaper_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  wire         s_axis_tlast,   // end_of_input
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast    // last
);
	import jsu_pkg::*;

	step_res_t step;
	res_t      m_res;
	logic      accept;
	logic      free;

	assign s_axis_tready = free;
	assign accept        = s_axis_tvalid && free;

	jsu_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (s_axis_tdata),
		.end_of_input (s_axis_tlast),
		.step         (step)
	);

	jsu_obuf u_obuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.step    (step),
		.free    (free),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_res   (m_res),
		.m_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {5'b00000, m_res.error_code, m_res.out_byte};
	assign m_axis_tuser = m_res.kind;

endmodule

`default_nettype wire
